// ===== rtl/rope_2d_pair_rotator_macros.svh =====
// Assertion macros used by the top RTL file of the pair rotator.
`ifndef ROPE_2D_PAIR_ROTATOR_MACROS_SVH
`define ROPE_2D_PAIR_ROTATOR_MACROS_SVH
`ifndef NO_ASSERTIONS
`define RP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define RP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RP_ASSERT_NOW(lbl, ante, cons, msg)
`define RP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/rp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rp_pkg;

	localparam int QUARTER = 16;
	localparam int POSITION_BITS = 16;
	localparam int DATA_BITS = 16;
	localparam int PAIR_BITS = 4;
	localparam int PAIRS = 1 << PAIR_BITS;
	localparam int LOG2_BITS = 22;
	localparam int CORDIC_STAGES = 24;
	localparam int CORDIC_PER_SLOT = 3;
	localparam int CORDIC_SLOTS = CORDIC_STAGES / CORDIC_PER_SLOT;

	localparam logic [31:0] INV_TWO_PI = 32'd683565276;
	localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic [0:0] CFG_LOG2_BASE = 1'b0;
	localparam logic [0:0] CFG_INVERSE = 1'b1;

	localparam logic signed [31:0] ATAN_TAB [CORDIC_STAGES] = '{
		32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
		32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
		32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
		32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
		32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
	};

	typedef struct packed {
		logic signed [DATA_BITS-1:0] u_value;
		logic signed [DATA_BITS-1:0] v_value;
		logic [POSITION_BITS-1:0] axis_position;
		logic [PAIR_BITS-1:0] pair_index;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] u_rotated;
		logic signed [DATA_BITS-1:0] v_rotated;
		logic saturated;
	} out_item_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bits;
		n = n_in;
		res = 64'd0;
		bits = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + bits) begin
				n = n - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] root_const(input int k);
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int j = 1; j <= k; j++) begin
			r = isqrt64(r << 32);
		end
		return r[31:0];
	endfunction

	localparam logic [31:0] ROOT_TAB [PAIRS] = '{
		root_const(1), root_const(2), root_const(3), root_const(4),
		root_const(5), root_const(6), root_const(7), root_const(8),
		root_const(9), root_const(10), root_const(11), root_const(12),
		root_const(13), root_const(14), root_const(15), root_const(16)
	};

endpackage
`default_nettype wire

// ===== rtl/rope_2d_pair_rotator.sv =====
// Rotary position embedding for one (u, v) pair per cycle. Once the rate table is
// built, an item enters every cycle unless out_ready holds the pipeline, and passes
// through a pipeline of input capture, phase multiply, CORDIC setup, eight CORDIC
// stages of three rotations each, quadrant mapping, products and rounding. After
// reset and after each write of log2_base the block rebuilds its sixteen-entry
// rate table, in sixteen steps per entry, and accepts no item during that time.
`timescale 1ns / 1ps
`default_nettype none
`include "rope_2d_pair_rotator_macros.svh"
module rope_2d_pair_rotator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire rp_pkg::in_item_t in_item,
	output logic out_valid,
	input wire logic out_ready,
	output rp_pkg::out_item_t out_item,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [rp_pkg::LOG2_BITS-1:0] cfg_data
);

	localparam int NSLOT = rp_pkg::CORDIC_SLOTS + 6;
	localparam int SL_C0 = 2;
	localparam int SL_MAP = SL_C0 + rp_pkg::CORDIC_SLOTS + 1;
	localparam int SL_MUL = SL_MAP + 1;
	localparam int SL_OUT = SL_MUL + 1;
	localparam int NC = rp_pkg::CORDIC_SLOTS + 1;

	logic [rp_pkg::LOG2_BITS-1:0] log2_base_q;
	logic inverse_q;
	logic rate_busy;
	logic [31:0] rate_rd;
	logic cfg_fire;
	logic in_fire;

	logic vld_s [NSLOT];
	logic en [NSLOT];

	logic signed [15:0] u_s1, v_s1, u_s2, v_s2;
	logic [15:0] p_s1;
	logic [31:0] rate_s1;
	logic [31:0] phase_s2;
	logic [47:0] pmul;
	logic [31:0] phase_adj;

	logic signed [31:0] cx_s [NC];
	logic signed [31:0] cy_s [NC];
	logic signed [31:0] cz_s [NC];
	logic [1:0] cq_s [NC];
	logic signed [15:0] cu_s [NC];
	logic signed [15:0] cv_s [NC];

	logic signed [31:0] cos_sm, sin_sm;
	logic signed [15:0] u_sm, v_sm;
	logic signed [47:0] uc_sp, vs_sp, vc_sp, us_sp;
	logic signed [48:0] su, sv;
	logic signed [18:0] ru, rv;
	rp_pkg::out_item_t out_s;

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_fire = in_valid && in_ready;
	assign in_ready = en[0] && !rate_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log2_base_q <= 22'd870823;
			inverse_q <= 1'b0;
		end else if (cfg_fire) begin
			unique case (cfg_index)
				rp_pkg::CFG_LOG2_BASE: log2_base_q <= cfg_data;
				rp_pkg::CFG_INVERSE: inverse_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rp_rate_gen u_rate (
		.clk(clk),
		.arst_n(arst_n),
		.start(cfg_fire && cfg_index == rp_pkg::CFG_LOG2_BASE),
		.log2_base(log2_base_q),
		.rd_index(in_item.pair_index),
		.rd_rate(rate_rd),
		.busy(rate_busy)
	);

	always_comb begin
		en[NSLOT-1] = !vld_s[NSLOT-1] || out_ready;
		for (int i = NSLOT - 2; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_fire;
			end
			for (int i = 1; i < NSLOT; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign pmul = 48'(p_s1) * 48'(rate_s1);
	assign phase_adj = inverse_q ? (32'd0 - phase_s2) : phase_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			u_s1 <= in_item.u_value;
			v_s1 <= in_item.v_value;
			p_s1 <= in_item.axis_position;
			rate_s1 <= rate_rd;
		end
		if (en[1]) begin
			u_s2 <= u_s1;
			v_s2 <= v_s1;
			phase_s2 <= pmul[31:0];
		end
		if (en[SL_C0]) begin
			cx_s[0] <= rp_pkg::CORDIC_GAIN;
			cy_s[0] <= '0;
			cz_s[0] <= {2'b00, phase_adj[29:0]};
			cq_s[0] <= phase_adj[31:30];
			cu_s[0] <= u_s2;
			cv_s[0] <= v_s2;
		end
	end

	for (genvar j = 1; j < NC; j++) begin : g_cordic
		localparam int BASE = (j - 1) * rp_pkg::CORDIC_PER_SLOT;
		logic signed [31:0] nx, ny, nz;
		always_comb begin
			logic signed [31:0] xs;
			logic signed [31:0] ys;
			nx = cx_s[j-1];
			ny = cy_s[j-1];
			nz = cz_s[j-1];
			for (int t = 0; t < rp_pkg::CORDIC_PER_SLOT; t++) begin
				xs = nx >>> (BASE + t);
				ys = ny >>> (BASE + t);
				if (!nz[31]) begin
					nx = nx - ys;
					ny = ny + xs;
					nz = nz - rp_pkg::ATAN_TAB[BASE + t];
				end else begin
					nx = nx + ys;
					ny = ny - xs;
					nz = nz + rp_pkg::ATAN_TAB[BASE + t];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[SL_C0 + j]) begin
				cx_s[j] <= nx;
				cy_s[j] <= ny;
				cz_s[j] <= nz;
				cq_s[j] <= cq_s[j-1];
				cu_s[j] <= cu_s[j-1];
				cv_s[j] <= cv_s[j-1];
			end
		end
	end

	assign su = 49'(uc_sp) - 49'(vs_sp) + (49'sd1 <<< 29);
	assign sv = 49'(vc_sp) + 49'(us_sp) + (49'sd1 <<< 29);
	assign ru = su[48:30];
	assign rv = sv[48:30];

	always_comb begin
		out_s.saturated = 1'b0;
		if (ru > 19'sd32767) begin
			out_s.u_rotated = 16'sh7FFF;
			out_s.saturated = 1'b1;
		end else if (ru < -19'sd32768) begin
			out_s.u_rotated = 16'sh8000;
			out_s.saturated = 1'b1;
		end else begin
			out_s.u_rotated = ru[15:0];
		end
		if (rv > 19'sd32767) begin
			out_s.v_rotated = 16'sh7FFF;
			out_s.saturated = 1'b1;
		end else if (rv < -19'sd32768) begin
			out_s.v_rotated = 16'sh8000;
			out_s.saturated = 1'b1;
		end else begin
			out_s.v_rotated = rv[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en[SL_MAP]) begin
			u_sm <= cu_s[NC-1];
			v_sm <= cv_s[NC-1];
			unique case (cq_s[NC-1])
				2'd0: begin
					cos_sm <= cx_s[NC-1];
					sin_sm <= cy_s[NC-1];
				end
				2'd1: begin
					cos_sm <= -cy_s[NC-1];
					sin_sm <= cx_s[NC-1];
				end
				2'd2: begin
					cos_sm <= -cx_s[NC-1];
					sin_sm <= -cy_s[NC-1];
				end
				default: begin
					cos_sm <= cy_s[NC-1];
					sin_sm <= -cx_s[NC-1];
				end
			endcase
		end
		if (en[SL_MUL]) begin
			uc_sp <= 48'(u_sm) * 48'(cos_sm);
			vs_sp <= 48'(v_sm) * 48'(sin_sm);
			vc_sp <= 48'(v_sm) * 48'(cos_sm);
			us_sp <= 48'(u_sm) * 48'(sin_sm);
		end
		if (en[SL_OUT]) begin
			out_item <= out_s;
		end
	end

	assign out_valid = vld_s[SL_OUT];

	`RP_ASSERT_NOW(a_no_accept_busy, in_valid && in_ready, !rate_busy,
		"Item accepted while the rate table was being rebuilt.")
	`RP_ASSERT_NEXT(a_rebuild_on_write, cfg_fire && cfg_index == rp_pkg::CFG_LOG2_BASE,
		rate_busy, "Rate table rebuild did not start after a base write.")
	`RP_ASSERT_NOW(a_sat_at_limit, out_valid && out_item.saturated,
		out_item.u_rotated == 16'sh7FFF || out_item.u_rotated == 16'sh8000 ||
		out_item.v_rotated == 16'sh7FFF || out_item.v_rotated == 16'sh8000,
		"Saturation flag set with both results inside the range.")

endmodule
`default_nettype wire

// ===== rtl/rp_rate_gen.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rp_rate_gen (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [rp_pkg::LOG2_BITS-1:0] log2_base,
	input wire logic [rp_pkg::PAIR_BITS-1:0] rd_index,
	output logic [31:0] rd_rate,
	output logic busy
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXP, ST_STEP, ST_HI, ST_RATE, ST_RATE_HI
	} state_t;

	localparam int EXP_BITS = rp_pkg::LOG2_BITS + rp_pkg::PAIR_BITS;

	state_t state_q;
	logic [rp_pkg::PAIR_BITS-1:0] d_q;
	logic [3:0] k_q;
	logic [15:0] ef_q;
	logic [5:0] ei_q;
	logic [31:0] acc_q;
	logic one_q;
	logic [47:0] lo_q;
	logic [31:0] table_q [rp_pkg::PAIRS];

	logic [EXP_BITS-1:0] e_full;
	logic [EXP_BITS-1:0] e_val;
	logic [31:0] mul_b;
	logic [47:0] mul_lo;
	logic [47:0] mul_hi;
	logic [63:0] prod;
	logic bit_set;

	always_comb begin
		e_full = EXP_BITS'(log2_base) * EXP_BITS'(d_q);
		e_val = e_full / EXP_BITS'(rp_pkg::QUARTER);
		mul_b = (state_q == ST_STEP || state_q == ST_HI) ? rp_pkg::ROOT_TAB[k_q]
			: rp_pkg::INV_TWO_PI;
		mul_lo = 48'(acc_q[15:0]) * 48'(mul_b);
		mul_hi = 48'(acc_q[31:16]) * 48'(mul_b);
		prod = {mul_hi, 16'd0} + {16'd0, lo_q};
		bit_set = ef_q[4'd15 - k_q];
	end

	assign rd_rate = table_q[rd_index];
	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EXP;
			d_q <= '0;
			k_q <= '0;
		end else if (start) begin
			state_q <= ST_EXP;
			d_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_EXP: begin
					ef_q <= e_val[15:0];
					ei_q <= e_val[21:16];
					one_q <= 1'b1;
					acc_q <= '0;
					k_q <= '0;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (bit_set && !one_q) begin
						lo_q <= mul_lo;
						state_q <= ST_HI;
					end else begin
						if (bit_set) begin
							acc_q <= rp_pkg::ROOT_TAB[k_q];
							one_q <= 1'b0;
						end
						k_q <= k_q + 4'd1;
						if (k_q == 4'd15) begin
							state_q <= ST_RATE;
						end
					end
				end
				ST_HI: begin
					acc_q <= prod[63:32];
					k_q <= k_q + 4'd1;
					state_q <= (k_q == 4'd15) ? ST_RATE : ST_STEP;
				end
				ST_RATE: begin
					if (one_q) begin
						table_q[d_q] <= rp_pkg::INV_TWO_PI >> ei_q;
						d_q <= d_q + 1'b1;
						state_q <= (d_q == '1) ? ST_IDLE : ST_EXP;
					end else begin
						lo_q <= mul_lo;
						state_q <= ST_RATE_HI;
					end
				end
				ST_RATE_HI: begin
					table_q[d_q] <= prod[63:32] >> ei_q;
					d_q <= d_q + 1'b1;
					state_q <= (d_q == '1) ? ST_IDLE : ST_EXP;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
module tb;

	localparam logic signed [63:0] ATANS [24] = '{
		64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4, 64'sh028B0D43,
		64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55, 64'sh0028BE53, 64'sh00145F2F,
		64'sh000A2F98, 64'sh000517CC, 64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA,
		64'sh0000517D, 64'sh000028BE, 64'sh0000145F, 64'sh00000A30, 64'sh00000518,
		64'sh0000028C, 64'sh00000146, 64'sh000000A3, 64'sh00000051
	};

	class rotation_board;
		bit [21:0] log2_base = 22'd870823;
		bit inverse = 1'b0;
		rp_pkg::out_item_t pending[$];
		int errors = 0;
		int checked = 0;

		function bit [63:0] root64(bit [63:0] n);
			bit [63:0] res;
			bit [63:0] b;
			res = 0;
			b = 64'd1 << 62;
			while (b > n) b = b >> 2;
			while (b != 0) begin
				if (n >= res + b) begin
					n = n - (res + b);
					res = (res >> 1) + b;
				end else begin
					res = res >> 1;
				end
				b = b >> 2;
			end
			return res;
		endfunction

		function logic signed [63:0] clip(logic signed [63:0] a, ref bit hit);
			if (a > 32767) begin
				hit = 1;
				return 32767;
			end
			if (a < -32768) begin
				hit = 1;
				return -32768;
			end
			return a;
		endfunction

		function void note_pair(rp_pkg::in_item_t it);
			bit [63:0] e, ei, ef, acc, r, rate, phase;
			logic signed [63:0] x, y, z, xs, ys, c, s, ru, rv, ua, va;
			bit hit;
			rp_pkg::out_item_t o;
			ua = it.u_value;
			va = it.v_value;
			e = (64'(log2_base) * 64'(it.pair_index)) / 64'(rp_pkg::QUARTER);
			ei = e >> 16;
			ef = e & 64'hFFFF;
			acc = 64'd1 << 32;
			r = 64'd1 << 31;
			for (int k = 1; k <= 16; k++) begin
				r = root64(r << 32);
				if (ef[16-k]) acc = (acc * r) >> 32;
			end
			rate = (acc * 64'd683565276) >> 32;
			rate = (ei >= 64) ? 64'd0 : (rate >> ei);
			phase = (64'(it.axis_position) * rate) & 64'hFFFFFFFF;
			if (inverse) phase = (64'h100000000 - phase) & 64'hFFFFFFFF;
			z = phase & 64'h3FFFFFFF;
			x = 64'sd652032874;
			y = 0;
			for (int i = 0; i < 24; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				if (z >= 0) begin
					x = x - ys;
					y = y + xs;
					z = z - ATANS[i];
				end else begin
					x = x + ys;
					y = y - xs;
					z = z + ATANS[i];
				end
			end
			case (phase[31:30])
				2'd0: begin c = x; s = y; end
				2'd1: begin c = -y; s = x; end
				2'd2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
			ru = (ua * c - va * s + (64'sd1 <<< 29)) >>> 30;
			rv = (va * c + ua * s + (64'sd1 <<< 29)) >>> 30;
			hit = 0;
			ru = clip(ru, hit);
			rv = clip(rv, hit);
			o.u_rotated = ru[15:0];
			o.v_rotated = rv[15:0];
			o.saturated = hit;
			pending.push_back(o);
		endfunction

		function void check_rotated(rp_pkg::out_item_t got);
			rp_pkg::out_item_t w;
			checked++;
			if (pending.size() == 0) begin
				$error("unexpected result item %h", got);
				errors++;
				return;
			end
			w = pending.pop_front();
			if (got.u_rotated !== w.u_rotated) begin
				$error("u_rotated expected %0d actual %0d", w.u_rotated, got.u_rotated);
				errors++;
			end
			if (got.v_rotated !== w.v_rotated) begin
				$error("v_rotated expected %0d actual %0d", w.v_rotated, got.v_rotated);
				errors++;
			end
			if (got.saturated !== w.saturated) begin
				$error("saturated expected %0d actual %0d", w.saturated, got.saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	rp_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 0;
	rp_pkg::out_item_t out_item;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [0:0] cfg_index = rp_pkg::CFG_LOG2_BASE;
	logic [rp_pkg::LOG2_BITS-1:0] cfg_data = '0;

	rotation_board board = new();
	longint cycles = 0;
	int sent = 0;
	bit draining = 0;

	always #2 clk = ~clk;

	rope_2d_pair_rotator u_top (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_rotated(out_item);
	end

	initial begin : sink
		int w;
		@(posedge arst_n);
		forever begin
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
			if (draining && $urandom_range(0, 1)) w = 0;
			if (w != 0) begin
				out_ready <= 0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	task automatic send_pair(rp_pkg::in_item_t it, bit burst);
		int w;
		w = burst ? 0 : $urandom_range(0, 8);
		if (w != 0) begin
			in_valid <= 0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_pair(it);
		sent++;
	endtask

	task automatic write_reg(logic [0:0] idx, logic [rp_pkg::LOG2_BITS-1:0] data);
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == rp_pkg::CFG_LOG2_BASE) board.log2_base = data;
		else board.inverse = data[0];
	endtask

	function automatic rp_pkg::in_item_t rand_pair();
		rp_pkg::in_item_t it;
		it.u_value = 16'($urandom);
		it.v_value = 16'($urandom);
		it.axis_position = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 64))
			: 16'($urandom);
		it.pair_index = 4'($urandom);
		return it;
	endfunction

	initial begin
		rp_pkg::in_item_t it;
		logic [rp_pkg::LOG2_BITS-1:0] bases[6];
		int burst;
		bases = '{22'd870823, 22'd0, 22'h3FFFFF, 22'd65536, 22'd2097152, 22'd0};
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (bases[b]) begin
			write_reg(rp_pkg::CFG_LOG2_BASE,
				(b == 5) ? rp_pkg::LOG2_BITS'($urandom) : bases[b]);
			write_reg(rp_pkg::CFG_INVERSE, rp_pkg::LOG2_BITS'(b % 2));
			if (b == 0) begin
				for (int k = 0; k < 16; k++) begin
					it.u_value = (k & 1) ? 16'sh7FFF : 16'sh8000;
					it.v_value = (k & 2) ? 16'sh7FFF : 16'sh8000;
					it.axis_position = (k < 4) ? 16'd0 : (k < 8) ? 16'hFFFF : 16'(k * 999);
					it.pair_index = 4'(k);
					send_pair(it, 0);
				end
			end
			burst = 0;
			for (int n = 0; n < 65; n++) begin
				if (burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(5, 20);
				send_pair(rand_pair(), burst != 0);
				if (burst != 0) burst--;
			end
		end
		draining = 1;
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Sent %0d pairs over six log2_base and inverse settings; checked %0d results.",
			sent, board.checked);
		if (board.errors == 0 && board.pending.size() == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end
endmodule
